FILE: sv/pdx_pkg.sv
// ----------------------------------------------------------------------------
// pdx_pkg: shared types and constants of the chained XOR deframer
// Frame phases, status codes, register indexes and the state/result records.
// ----------------------------------------------------------------------------
package pdx_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_KEY  = 1'b0,
    CFG_FRAME_CODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_CODE    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_KEY     = 3'd3,
    PH_SUM     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_CODE = 2'd3
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic [LEN_W-1:0]  remaining;
    logic [BYTE_W-1:0] random_key;
    logic [BYTE_W-1:0] prev_cipher;
    logic [BYTE_W-1:0] prev_stage_one;
    logic [BYTE_W-1:0] position;
    logic [BYTE_W-1:0] running_sum;
    logic [BYTE_W-1:0] expected_sum;
    logic              halted;
  } dec_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              frame_last;
    status_t           status;
  } dec_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] fixed_key;
    logic [BYTE_W-1:0] frame_code;
  } dec_cfg_t;

  localparam dec_state_t STATE_RESET = '{
    phase:          PH_CODE,
    remaining:      '0,
    random_key:     '0,
    prev_cipher:    '0,
    prev_stage_one: '0,
    position:       BYTE_W'(1),
    running_sum:    '0,
    expected_sum:   '0,
    halted:         1'b0
  };

endpackage

FILE: sv/pdx_if.sv
// ----------------------------------------------------------------------------
// pdx_if: stream channels of the chained XOR deframer
// Byte input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdx_in_if;
  logic                          valid;
  logic                          ready;
  logic [pdx_pkg::BYTE_W-1:0]    byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface pdx_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdx_pkg::BYTE_W-1:0]    data_out;
  logic                          data_valid;
  logic                          frame_last;
  logic [1:0]                    status;

  modport source (output valid, output data_out, output data_valid,
                  output frame_last, output status, input ready);
  modport sink   (input valid, input data_out, input data_valid,
                  input frame_last, input status, output ready);
endinterface

FILE: sv/pdx_step.sv
// ----------------------------------------------------------------------------
// pdx_step: per-byte deframe and decode logic
// Computes the next frame state and the optional result for one byte.
// ----------------------------------------------------------------------------
module pdx_step (
  input  pdx_pkg::dec_state_t            cur,
  input  pdx_pkg::dec_cfg_t              cfg,
  input  logic [pdx_pkg::BYTE_W-1:0]     byte_in,
  output pdx_pkg::dec_state_t            nxt,
  output pdx_pkg::dec_result_t           res,
  output logic                           emit
);

  logic [pdx_pkg::BYTE_W-1:0] stage_one;
  logic [pdx_pkg::BYTE_W-1:0] plain;
  logic [pdx_pkg::BYTE_W-1:0] sum_nxt;
  logic [pdx_pkg::LEN_W-1:0]  rem_dec;

  assign stage_one = byte_in ^ (cur.prev_cipher + cfg.fixed_key + cur.position);
  assign plain     = stage_one ^ (cur.prev_stage_one + cur.random_key + cur.position);
  assign sum_nxt   = cur.running_sum + plain;
  assign rem_dec   = cur.remaining - pdx_pkg::LEN_W'(1);

  always_comb begin
    nxt  = cur;
    res  = '{data_out: '0, data_valid: 1'b0, frame_last: 1'b0,
             status: pdx_pkg::ST_BUSY};
    emit = 1'b0;
    if (!cur.halted) begin
      unique case (cur.phase)
        pdx_pkg::PH_CODE: begin
          if (byte_in != cfg.frame_code) begin
            nxt.halted     = 1'b1;
            emit           = 1'b1;
            res.frame_last = 1'b1;
            res.status     = pdx_pkg::ST_CODE;
          end else begin
            nxt.phase = pdx_pkg::PH_LEN_LO;
          end
        end
        pdx_pkg::PH_LEN_LO: begin
          nxt.remaining = {{(pdx_pkg::LEN_W-pdx_pkg::BYTE_W){1'b0}}, byte_in};
          nxt.phase     = pdx_pkg::PH_LEN_HI;
        end
        pdx_pkg::PH_LEN_HI: begin
          nxt.remaining = {byte_in, cur.remaining[pdx_pkg::BYTE_W-1:0]};
          nxt.phase     = pdx_pkg::PH_KEY;
        end
        pdx_pkg::PH_KEY: begin
          nxt.random_key     = byte_in;
          nxt.prev_cipher    = '0;
          nxt.prev_stage_one = '0;
          nxt.position       = pdx_pkg::BYTE_W'(1);
          nxt.running_sum    = '0;
          nxt.phase          = pdx_pkg::PH_SUM;
        end
        pdx_pkg::PH_SUM: begin
          nxt.expected_sum   = plain;
          nxt.prev_cipher    = byte_in;
          nxt.prev_stage_one = stage_one;
          nxt.position       = cur.position + pdx_pkg::BYTE_W'(1);
          if (cur.remaining != '0) begin
            nxt.phase = pdx_pkg::PH_PAYLOAD;
          end else begin
            nxt.phase      = pdx_pkg::PH_CODE;
            emit           = 1'b1;
            res.frame_last = 1'b1;
            if (plain == '0) begin
              res.status = pdx_pkg::ST_GOOD;
            end else begin
              res.status = pdx_pkg::ST_BAD;
              nxt.halted = 1'b1;
            end
          end
        end
        pdx_pkg::PH_PAYLOAD: begin
          nxt.prev_cipher    = byte_in;
          nxt.prev_stage_one = stage_one;
          nxt.position       = cur.position + pdx_pkg::BYTE_W'(1);
          nxt.running_sum    = sum_nxt;
          nxt.remaining      = rem_dec;
          emit               = 1'b1;
          res.data_out       = plain;
          res.data_valid     = 1'b1;
          if (rem_dec == '0) begin
            nxt.phase      = pdx_pkg::PH_CODE;
            res.frame_last = 1'b1;
            if (sum_nxt == cur.expected_sum) begin
              res.status = pdx_pkg::ST_GOOD;
            end else begin
              res.status = pdx_pkg::ST_BAD;
              nxt.halted = 1'b1;
            end
          end
        end
        default: begin
          nxt.phase = pdx_pkg::PH_CODE;
        end
      endcase
    end
  end

endmodule

FILE: sv/packet_deframer_chained_xor_decoder_unit.sv
// ----------------------------------------------------------------------------
// packet_deframer_chained_xor_decoder_unit: chained XOR frame decoder
// Output: a result is registered, shown in the cycle after its byte transaction.
// Throughput: one byte per cycle unless the output stalls; the frame state and
//   an emitted result are registered in the same cycle the byte is taken.
// Reset: synchronous active-low rst_n clears keys, frame state and halt flag.
// ----------------------------------------------------------------------------
module packet_deframer_chained_xor_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  pdx_in_if.sink                            in_ch,
  pdx_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pdx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdx_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pdx_pkg::dec_cfg_t    cfg_r;
  pdx_pkg::dec_state_t  state_r;
  pdx_pkg::dec_state_t  state_nxt;
  pdx_pkg::dec_result_t res_nxt;
  pdx_pkg::dec_result_t res_r;
  logic                 emit;
  logic                 out_valid_r;
  logic                 in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  pdx_step u_step (
    .cur     (state_r),
    .cfg     (cfg_r),
    .byte_in (in_ch.byte_in),
    .nxt     (state_nxt),
    .res     (res_nxt),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (pdx_pkg::cfg_idx_t'(cfg_index))
        pdx_pkg::CFG_FIXED_KEY:  cfg_r.fixed_key  <= cfg_data;
        pdx_pkg::CFG_FRAME_CODE: cfg_r.frame_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdx_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_out   = res_r.data_out;
  assign out_ch.data_valid = res_r.data_valid;
  assign out_ch.frame_last = res_r.frame_last;
  assign out_ch.status     = res_r.status;

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt flag cleared without reset");

  a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == pdx_pkg::PH_PAYLOAD) |-> (state_r.remaining != '0))
    else $error("payload phase with no bytes remaining");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.data_valid) |-> (res_r.data_out == '0 && res_r.frame_last))
    else $error("non-data result must be a zero frame end");

  a_busy_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.frame_last) |-> (res_r.status == pdx_pkg::ST_BUSY))
    else $error("mid-frame result carries final status");

  a_halt_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r.halted) |=> (state_r == $past(state_r)))
    else $error("halted block changed frame state");
`endif

endmodule
